@@ sv/led_driver_pulse_step_sequencer_core_macros.svh @@
// Assertion macros for the LED pulse step sequencer.
// Needs signals named clock and reset in the scope of each use.
`ifndef LED_DRIVER_PULSE_STEP_SEQUENCER_CORE_MACROS_SVH
`define LED_DRIVER_PULSE_STEP_SEQUENCER_CORE_MACROS_SVH

// Same-cycle implication, off while reset is high.
`define LPSS_ASSERT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("lpss check failed");

// Next-cycle implication, off while reset is high.
`define LPSS_ASSERT_NEXT(label, ante, cons) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("lpss check failed");

`endif

@@ sv/lpss_pkg.sv @@
// Shared constants, types and the level decode function of the LED pulse step sequencer.
// No dependencies.
`default_nettype none

package lpss_pkg;

   localparam int SLOTS_PER_FRAME = 50;
   localparam int TOP_STEP        = 31;
   localparam int POWER_ON_STEP   = 16;

   localparam int LEVEL_FLOOR     = 7;
   localparam int LEVEL_RATIO_LOG2 = 3;

   localparam int LEVEL_W   = 8;
   localparam int COMPARE_W = 16;
   localparam int STEP_W    = 5;
   localparam int SLOT_W    = 6;
   localparam int CSR_IDX_W = 2;

   localparam logic [COMPARE_W-1:0] IDLE_COMPARE       = 16'hFFFF;
   localparam logic [LEVEL_W-1:0]   LEVEL_CLIP_RESET   = 8'd255;
   localparam logic [COMPARE_W-1:0] UP_COMPARE_RESET   = 16'd27200;
   localparam logic [COMPARE_W-1:0] DOWN_COMPARE_RESET = 16'd320;

   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic {
      OP_LEVEL = 1'b0,
      OP_TICK  = 1'b1
   } op_type;

   typedef enum logic [1:0] {
      FRAME_IDLE   = 2'd0,
      FRAME_UP     = 2'd1,
      FRAME_DOWN   = 2'd2,
      FRAME_DITHER = 2'd3
   } frame_mode_type;

   typedef enum logic [1:0] {
      PULSE_IDLE = 2'd0,
      PULSE_UP   = 2'd1,
      PULSE_DOWN = 2'd2
   } pulse_kind_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_LEVEL_CLIP   = 2'd0,
      CSR_UP_COMPARE   = 2'd1,
      CSR_DOWN_COMPARE = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [LEVEL_W-1:0] clipped;
      logic               on;
      logic [STEP_W-1:0]  target;
      logic [SLOT_W-1:0]  dither;
   } level_decode_type;

   typedef struct packed {
      op_type             op;
      logic [LEVEL_W-1:0] raw;
      level_decode_type   dec;
   } queue_entry_type;

   typedef struct packed {
      logic            valid;
      queue_entry_type entry;
   } queue_slot_type;

   typedef struct packed {
      logic                 reapply;
      logic [LEVEL_W-1:0]   level_clip;
      logic [COMPARE_W-1:0] up_compare;
      logic [COMPARE_W-1:0] down_compare;
   } back_cfg_type;

   // Clip, then split (level - floor) into a step and a dither slot.
   function automatic level_decode_type decode_level(input logic [LEVEL_W-1:0] raw,
                                                     input logic [LEVEL_W-1:0] level_clip);
      logic [LEVEL_W-1:0]  c;
      logic [LEVEL_W-1:0]  rel;
      logic [STEP_W-1:0]   q;
      logic [2:0]          r;
      logic [8:0]          prod;
      level_decode_type    d;
      c    = (raw < level_clip) ? raw : level_clip;
      rel  = c - LEVEL_W'(LEVEL_FLOOR);
      q    = rel[LEVEL_W-1:LEVEL_RATIO_LOG2];
      r    = rel[LEVEL_RATIO_LOG2-1:0];
      if (q > STEP_W'(TOP_STEP)) begin
         q = STEP_W'(TOP_STEP);
         r = '0;
      end
      prod      = 9'(r) * 9'(SLOTS_PER_FRAME);
      d.clipped = c;
      d.on      = (c >= LEVEL_W'(LEVEL_FLOOR));
      d.target  = d.on ? q : '0;
      d.dither  = d.on ? prod[8:LEVEL_RATIO_LOG2] : '0;
      return d;
   endfunction

endpackage

`default_nettype wire

@@ sv/lpss_if.sv @@
// Request and response channel interfaces of the LED pulse step sequencer.
// Depends on lpss_pkg.
`default_nettype none

interface lpss_req_if;
   logic                          valid;
   logic                          ready;
   logic                          func;
   logic [lpss_pkg::LEVEL_W-1:0]  level;

   modport source (output valid, output func, output level, input ready);
   modport sink   (input valid, input func, input level, output ready);
endinterface

interface lpss_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [lpss_pkg::COMPARE_W-1:0]  compare_value;
   logic [1:0]                      pulse_kind;
   logic                            chip_enable;
   logic [lpss_pkg::LEVEL_W-1:0]    reported_level;

   modport source (output valid, output compare_value, output pulse_kind,
                   output chip_enable, output reported_level, input ready);
   modport sink   (input valid, input compare_value, input pulse_kind,
                   input chip_enable, input reported_level, output ready);
endinterface

`default_nettype wire

@@ sv/led_driver_pulse_step_sequencer_core.sv @@
// Top level of the LED pulse step sequencer: configuration registers and stage wiring.
// Depends on lpss_pkg, lpss_if, lpss_front, lpss_queue and lpss_back.
`default_nettype none

// Sequencer for a single-wire, step-programmed LED current chip. Each request is
// either a level request (func 0) or a slot tick (func 1), and each request gives
// exactly one response. A level is clipped to the level clip register; clipped
// levels below 7 turn the chip off, otherwise (level - 7) / 8 is the target current
// step (0..31) and the remainder picks a dither slot inside a frame of
// SLOTS_PER_FRAME ticks. On every tick the response carries one timer compare value:
// idle (65535), the up-pulse compare or the down-pulse compare, with pulse_kind
// saying which. Frames are planned on their first tick: step pulses when the chip
// step differs from the target, else, for a nonzero dither slot, an up pulse in slot
// 0 and a down pulse in the dither slot. After turn-on the chip sits at step 16 and
// the first frame keeps slot 0 idle. Requests are taken at one per clock while the
// response side keeps up; each response passes the front decode register, the
// two-entry queue and the response register, and a stalled response side
// fills the queue before the request side backs up. Configuration writes take effect
// at the write edge; writing the level clip re-applies the last raw level at once.
// Write configuration only while no request is in flight.

module led_driver_pulse_step_sequencer_core (
   input  wire logic                            clock,
   input  wire logic                            reset,
   lpss_req_if.sink                             req,
   lpss_rsp_if.source                           rsp,
   input  wire logic                            csr_write_enable,
   input  wire logic [lpss_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [lpss_pkg::COMPARE_W-1:0]  csr_write_data
);
   import lpss_pkg::*;

   // Configuration registers
   logic [LEVEL_W-1:0]    level_clip_ff, level_clip_in;
   logic [COMPARE_W-1:0]  up_compare_ff, up_compare_in;
   logic [COMPARE_W-1:0]  down_compare_ff, down_compare_in;
   logic                  reapply;

   queue_slot_type        push;
   queue_slot_type        head;
   logic                  queue_full;
   logic                  pop;
   back_cfg_type          back_cfg;

   // Decode the write; an index past the register list is dropped.
   always_comb begin
      level_clip_in   = level_clip_ff;
      up_compare_in   = up_compare_ff;
      down_compare_in = down_compare_ff;
      reapply         = 1'b0;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_LEVEL_CLIP: begin
               level_clip_in = csr_write_data[LEVEL_W-1:0];
               reapply       = 1'b1;
            end
            CSR_UP_COMPARE:   up_compare_in   = csr_write_data;
            CSR_DOWN_COMPARE: down_compare_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_clip_ff   <= LEVEL_CLIP_RESET;
         up_compare_ff   <= UP_COMPARE_RESET;
         down_compare_ff <= DOWN_COMPARE_RESET;
      end else begin
         level_clip_ff   <= level_clip_in;
         up_compare_ff   <= up_compare_in;
         down_compare_ff <= down_compare_in;
      end
   end

   // Re-apply uses the value being written, so the back stage sees the new
   // clip in the same edge as the register update.
   assign back_cfg.reapply      = reapply;
   assign back_cfg.level_clip   = level_clip_in;
   assign back_cfg.up_compare   = up_compare_ff;
   assign back_cfg.down_compare = down_compare_ff;

   // Front: accept and decode requests.
   lpss_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req),
      .level_clip (level_clip_ff),
      .queue_full (queue_full),
      .push       (push)
   );

   // Queue: lets front and back stall independently.
   lpss_queue u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .pop   (pop),
      .full  (queue_full),
      .head  (head)
   );

   // Back: run the sequencer and hold the response.
   lpss_back u_back (
      .clock (clock),
      .reset (reset),
      .head  (head),
      .cfg   (back_cfg),
      .pop   (pop),
      .rsp   (rsp)
   );

endmodule

`default_nettype wire

@@ sv/lpss_front.sv @@
// Front stage: takes requests, classifies them and decodes levels into queue entries.
// Depends on lpss_pkg and lpss_if.
`default_nettype none

module lpss_front (
   input  wire logic                          clock,
   input  wire logic                          reset,
   lpss_req_if.sink                           req,
   input  wire logic [lpss_pkg::LEVEL_W-1:0]  level_clip,
   input  wire logic                          queue_full,
   output lpss_pkg::queue_slot_type           push
);
   import lpss_pkg::*;

   logic            valid_ff, valid_in;
   queue_entry_type entry_ff, entry_in;
   logic            take;

   // Advance when the stage is empty or its entry moves into the queue.
   assign req.ready = !valid_ff || !queue_full;
   assign take      = req.valid && req.ready;

   always_comb begin
      entry_in.op  = req.func ? OP_TICK : OP_LEVEL;
      entry_in.raw = req.level;
      entry_in.dec = decode_level(req.level, level_clip);
      valid_in     = take || (valid_ff && queue_full);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         entry_ff <= entry_in;
      end
   end

   assign push.valid = valid_ff;
   assign push.entry = entry_ff;

endmodule

`default_nettype wire

@@ sv/lpss_queue.sv @@
// Short FIFO between the front and back stages.
// Depends on lpss_pkg.
`default_nettype none

module lpss_queue (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire lpss_pkg::queue_slot_type push,
   input  wire logic                     pop,
   output logic                          full,
   output lpss_pkg::queue_slot_type      head
);
   import lpss_pkg::*;

   queue_entry_type         mem_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_W-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_W-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_CNT_W-1:0]  count_ff, count_in;
   logic                    do_push;
   logic                    do_pop;

   assign full    = (count_ff == QUEUE_CNT_W'(QUEUE_DEPTH));
   assign do_push = push.valid && !full;
   assign do_pop  = pop && (count_ff != '0);

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == QUEUE_PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.entry;
      end
   end

   assign head.valid = (count_ff != '0);
   assign head.entry = mem_ff[rd_ptr_ff];

endmodule

`default_nettype wire

@@ sv/lpss_back.sv @@
// Back stage: sequencer state, frame planning per tick, and the response register.
// Depends on lpss_pkg and lpss_if.
`default_nettype none

module lpss_back (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire lpss_pkg::queue_slot_type head,
   input  wire lpss_pkg::back_cfg_type   cfg,
   output logic                          pop,
   lpss_rsp_if.source                    rsp
);
   import lpss_pkg::*;

   // Sequencer state
   logic                  is_on_ff, is_on_in;
   logic [LEVEL_W-1:0]    raw_ff, raw_in;
   logic [LEVEL_W-1:0]    clipped_ff, clipped_in;
   logic [STEP_W-1:0]     target_ff, target_in;
   logic [SLOT_W-1:0]     dither_ff, dither_in;
   logic [STEP_W-1:0]     chip_ff, chip_in;
   logic [SLOT_W-1:0]     slot_ff, slot_in;
   frame_mode_type        mode_ff, mode_in;
   logic [SLOT_W-1:0]     count_ff, count_in;
   logic                  first_ff, first_in;

   // Response register
   logic                  out_valid_ff, out_valid_in;
   logic [COMPARE_W-1:0]  out_compare_ff, out_compare_in;
   pulse_kind_type        out_kind_ff, out_kind_in;
   logic                  out_enable_ff, out_enable_in;
   logic [LEVEL_W-1:0]    out_level_ff, out_level_in;

   // Tick evaluation
   logic [SLOT_W-1:0]     s;
   logic                  plan;
   logic                  off;
   logic [SLOT_W-1:0]     cap;
   logic [STEP_W-1:0]     diff;
   logic [SLOT_W-1:0]     n;
   frame_mode_type        t_mode;
   logic [SLOT_W-1:0]     t_count;
   logic [STEP_W-1:0]     t_chip;
   logic [SLOT_W:0]       pulse_end;
   logic [SLOT_W:0]       s_next;
   pulse_kind_type        t_kind;

   level_decode_type      dec;
   logic                  apply_en;
   logic                  is_tick;

   always_comb begin
      s    = (slot_ff >= SLOT_W'(SLOTS_PER_FRAME)) ? '0 : slot_ff;
      plan = (s == '0);
      off  = first_ff;
      cap  = SLOT_W'(SLOTS_PER_FRAME) - SLOT_W'(off);
      diff = (target_ff > chip_ff) ? target_ff - chip_ff : chip_ff - target_ff;
      n    = (SLOT_W'(diff) < cap) ? SLOT_W'(diff) : cap;

      t_mode  = mode_ff;
      t_count = count_ff;
      t_chip  = chip_ff;
      if (plan) begin
         if (target_ff != chip_ff) begin
            t_count = n;
            if (target_ff > chip_ff) begin
               t_mode = FRAME_UP;
               t_chip = chip_ff + n[STEP_W-1:0];
            end else begin
               t_mode = FRAME_DOWN;
               t_chip = chip_ff - n[STEP_W-1:0];
            end
         end else if (dither_ff != '0 && !first_ff) begin
            t_mode  = FRAME_DITHER;
            t_count = dither_ff;
         end else begin
            t_mode  = FRAME_IDLE;
            t_count = '0;
         end
      end

      pulse_end = {1'b0, t_count} + (SLOT_W + 1)'(off);
      t_kind    = PULSE_IDLE;
      case (t_mode)
         FRAME_UP: begin
            if (s >= SLOT_W'(off) && {1'b0, s} < pulse_end) t_kind = PULSE_UP;
         end
         FRAME_DOWN: begin
            if (s >= SLOT_W'(off) && {1'b0, s} < pulse_end) t_kind = PULSE_DOWN;
         end
         FRAME_DITHER: begin
            if (s == '0) begin
               t_kind = PULSE_UP;
            end else if (s == t_count) begin
               t_kind = PULSE_DOWN;
            end
         end
         default: t_kind = PULSE_IDLE;
      endcase

      s_next = {1'b0, s} + 1'b1;
   end

   always_comb begin
      pop      = head.valid && (!out_valid_ff || rsp.ready);
      is_tick  = pop && (head.entry.op == OP_TICK);
      apply_en = cfg.reapply || (pop && head.entry.op == OP_LEVEL);
      dec      = cfg.reapply ? decode_level(raw_ff, cfg.level_clip) : head.entry.dec;

      is_on_in   = is_on_ff;
      raw_in     = raw_ff;
      clipped_in = clipped_ff;
      target_in  = target_ff;
      dither_in  = dither_ff;
      chip_in    = chip_ff;
      slot_in    = slot_ff;
      mode_in    = mode_ff;
      count_in   = count_ff;
      first_in   = first_ff;

      if (pop && head.entry.op == OP_LEVEL) begin
         raw_in = head.entry.raw;
      end

      if (apply_en) begin
         clipped_in = dec.clipped;
         target_in  = dec.target;
         dither_in  = dec.dither;
         if (!dec.on) begin
            // Drop the chip and clear the whole frame.
            is_on_in = 1'b0;
            chip_in  = '0;
            first_in = 1'b0;
            slot_in  = '0;
            mode_in  = FRAME_IDLE;
            count_in = '0;
         end else if (!is_on_ff) begin
            is_on_in = 1'b1;
            chip_in  = STEP_W'(POWER_ON_STEP);
            first_in = 1'b1;
            slot_in  = '0;
            mode_in  = FRAME_IDLE;
            count_in = '0;
         end
      end

      if (is_tick && is_on_ff) begin
         mode_in  = t_mode;
         count_in = t_count;
         chip_in  = t_chip;
         if (s_next >= (SLOT_W + 1)'(SLOTS_PER_FRAME)) begin
            slot_in  = '0;
            first_in = 1'b0;
         end else begin
            slot_in = s_next[SLOT_W-1:0];
         end
      end

      out_valid_in   = out_valid_ff && !rsp.ready;
      out_compare_in = out_compare_ff;
      out_kind_in    = out_kind_ff;
      out_enable_in  = out_enable_ff;
      out_level_in   = out_level_ff;
      if (pop) begin
         out_valid_in  = 1'b1;
         out_kind_in   = (is_tick && is_on_ff) ? t_kind : PULSE_IDLE;
         out_enable_in = is_on_in;
         out_level_in  = clipped_in;
         case (out_kind_in)
            PULSE_UP:   out_compare_in = cfg.up_compare;
            PULSE_DOWN: out_compare_in = cfg.down_compare;
            default:    out_compare_in = IDLE_COMPARE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         is_on_ff     <= 1'b0;
         raw_ff       <= '0;
         clipped_ff   <= '0;
         target_ff    <= '0;
         dither_ff    <= '0;
         chip_ff      <= '0;
         slot_ff      <= '0;
         mode_ff      <= FRAME_IDLE;
         count_ff     <= '0;
         first_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         is_on_ff     <= is_on_in;
         raw_ff       <= raw_in;
         clipped_ff   <= clipped_in;
         target_ff    <= target_in;
         dither_ff    <= dither_in;
         chip_ff      <= chip_in;
         slot_ff      <= slot_in;
         mode_ff      <= mode_in;
         count_ff     <= count_in;
         first_ff     <= first_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_compare_ff <= out_compare_in;
      out_kind_ff    <= out_kind_in;
      out_enable_ff  <= out_enable_in;
      out_level_ff   <= out_level_in;
   end

   assign rsp.valid          = out_valid_ff;
   assign rsp.compare_value  = out_compare_ff;
   assign rsp.pulse_kind     = 2'(out_kind_ff);
   assign rsp.chip_enable    = out_enable_ff;
   assign rsp.reported_level = out_level_ff;

endmodule

`default_nettype wire

@@ sv/lpss_checker.sv @@
// Port-level checks of the LED pulse step sequencer, bound to the top level.
// Depends on lpss_pkg and the assertion macro header.
`default_nettype none

`include "led_driver_pulse_step_sequencer_core_macros.svh"

module lpss_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_ready,
   input  wire logic [lpss_pkg::COMPARE_W-1:0]  rsp_compare_value,
   input  wire logic [1:0]                      rsp_pulse_kind,
   input  wire logic                            rsp_chip_enable,
   input  wire logic [lpss_pkg::LEVEL_W-1:0]    rsp_reported_level
);
   import lpss_pkg::*;

   // A stalled response holds its payload.
   `LPSS_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_compare_value) && $stable(rsp_pulse_kind) && $stable(rsp_reported_level))

   // A pulse is only sent while the chip is enabled.
   `LPSS_ASSERT(a_pulse_needs_enable, rsp_valid && rsp_pulse_kind != 2'(PULSE_IDLE), rsp_chip_enable)

   // An idle slot carries the idle compare value.
   `LPSS_ASSERT(a_idle_compare, rsp_valid && rsp_pulse_kind == 2'(PULSE_IDLE), rsp_compare_value == IDLE_COMPARE)

   // The chip is off only for levels below the turn-on threshold.
   `LPSS_ASSERT(a_off_level, rsp_valid && !rsp_chip_enable, rsp_reported_level < LEVEL_W'(LEVEL_FLOOR))

endmodule

bind led_driver_pulse_step_sequencer_core lpss_checker u_lpss_checker (
   .clock              (clock),
   .reset              (reset),
   .rsp_valid          (rsp.valid),
   .rsp_ready          (rsp.ready),
   .rsp_compare_value  (rsp.compare_value),
   .rsp_pulse_kind     (rsp.pulse_kind),
   .rsp_chip_enable    (rsp.chip_enable),
   .rsp_reported_level (rsp.reported_level)
);

`default_nettype wire
